/* hdl/tet_element_current_density_assert.svh */
// Assertion macros shared by the element current density checker.
`ifndef TET_ELEMENT_CURRENT_DENSITY_ASSERT_SVH
`define TET_ELEMENT_CURRENT_DENSITY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TECD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TECD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tecd_pkg.sv */
// Types, constants and helper functions of the element current density block.
package tecd_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_NODES    = 20;
    localparam int ACC_W        = 65;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int FSUM_W       = 54;
    localparam int DIV_W        = FSUM_W + 1;
    localparam int DIV_STEP     = 11;
    localparam int DIV_ROUNDS   = DIV_W / DIV_STEP;
    localparam int DIV_CW       = $clog2(DIV_ROUNDS);
    localparam int DRAIN_CYCLES = 3;
    localparam int NODE_W       = $clog2(MAX_NODES);

    localparam logic [1:0] MODE_CORNER = 2'd0;
    localparam logic [1:0] MODE_NODE   = 2'd1;
    localparam logic [1:0] MODE_COND   = 2'd2;
    localparam logic [1:0] MODE_PRIOR  = 2'd3;

    localparam logic [1:0] ORD_LIN  = 2'd1;
    localparam logic [1:0] ORD_QUAD = 2'd2;
    localparam logic [1:0] ORD_CUB  = 2'd3;

    localparam logic [3:0] DIVISOR   = 4'd6;
    localparam logic [2:0] DIV_ROUND = 3'd3;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam q_t   Q_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t   Q_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam acc_t ONE_ACC = 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_COF, ST_C0, ST_WGT, ST_POT,
        ST_DIV, ST_DIVW, ST_TEN, ST_DRAIN, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_DIFF, OP_COF, OP_C0, OP_WGT, OP_POT,
        OP_DIV, OP_DIVW, OP_TEN, OP_EMIT
    } op_t;

    typedef enum logic [1:0] {TGT_NONE, TGT_COF, TGT_WGT, TGT_CUR} tgt_t;

    typedef struct packed {
        op_t               op;
        logic              first;
        logic              commit;
        logic              t;
        logic [1:0]        j;
        logic [1:0]        k;
        logic [NODE_W-1:0] n;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       neg;
        logic       rnd;
        logic       acc_b;
        logic       prior;
        tgt_t       tgt;
        logic [3:0] idx;
        logic [1:0] j;
    } pipe_ctl_t;

    function automatic logic [1:0] eff_order(input logic [1:0] ord);
        return (ord == 2'd0) ? ORD_LIN : ord;
    endfunction

    function automatic logic [NODE_W-1:0] node_first(input logic [1:0] ord);
        return (eff_order(ord) == ORD_QUAD) ? NODE_W'(4) : NODE_W'(0);
    endfunction

    function automatic logic [NODE_W-1:0] node_last(input logic [1:0] ord);
        logic [NODE_W-1:0] r;
        begin
            unique case (eff_order(ord))
                ORD_QUAD: r = NODE_W'(9);
                ORD_CUB:  r = NODE_W'(MAX_NODES - 1);
                default:  r = NODE_W'(3);
            endcase
            return r;
        end
    endfunction

    // flat index row*3 + col
    function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
        return 4'({r, 1'b0}) + 4'(r) + 4'(c);
    endfunction

    // corner pair of edge e
    function automatic logic [3:0] edge_pair(input logic [2:0] e);
        logic [3:0] p;
        begin
            case (e)
                3'd0:    p = {2'd0, 2'd1};
                3'd1:    p = {2'd0, 2'd2};
                3'd2:    p = {2'd0, 2'd3};
                3'd3:    p = {2'd1, 2'd2};
                3'd4:    p = {2'd1, 2'd3};
                default: p = {2'd2, 2'd3};
            endcase
            return p;
        end
    endfunction

    // shape gradient weight of node n on corner k, units of 1/32
    function automatic logic signed [7:0] shape_coef(input logic [1:0] ord,
                                                     input logic [4:0] n,
                                                     input logic [1:0] k);
        logic signed [7:0] c;
        logic [3:0]        pr;
        logic [4:0]        nm;
        begin
            c  = '0;
            nm = n - 5'd4;
            pr = '0;
            unique case (eff_order(ord))
                ORD_QUAD: begin
                    if (n >= 5'd4 && n <= 5'd9) begin
                        pr = edge_pair(nm[2:0]);
                        if (k == pr[3:2] || k == pr[1:0])
                            c = 8'sd32;
                    end
                end
                ORD_CUB: begin
                    if (n < 5'd4) begin
                        if (k == n[1:0])
                            c = -8'sd13;
                    end else if (n < 5'd16) begin
                        pr = edge_pair(nm[3:1]);
                        if (k == pr[3:2])
                            c = n[0] ? -8'sd9 : 8'sd18;
                        else if (k == pr[1:0])
                            c = n[0] ? 8'sd18 : -8'sd9;
                    end else if (k != 2'(5'd19 - n)) begin
                        c = 8'sd54;
                    end
                end
                default: begin
                    if (n < 5'd4 && k == n[1:0])
                        c = 8'sd32;
                end
            endcase
            return c;
        end
    endfunction

    // x / 2^sh rounded to nearest, ties away from zero
    function automatic acc_t rnd_shr(input acc_t x, input int unsigned sh);
        acc_t h;
        begin
            h = ONE_ACC <<< (sh - 1);
            if (x[ACC_W-1])
                return (x + h - ONE_ACC) >>> sh;
            return (x + h) >>> sh;
        end
    endfunction

    function automatic q_t sat32(input acc_t x);
        if (x[ACC_W-1:DATA_W-1] == '0 || x[ACC_W-1:DATA_W-1] == '1)
            return x[DATA_W-1:0];
        return x[ACC_W-1] ? Q_MIN : Q_MAX;
    endfunction

    function automatic acc_t ext(input q_t x);
        return ACC_W'(x);
    endfunction

endpackage

/* hdl/tet_element_current_density.sv */
// Top level of the tetrahedral element current density block.
//
// Input stream (s_*): one item per accepted beat. s_tuser carries mode and
// slot, s_tdata the four Q16.16 values, s_tlast closes the element. Items
// load straight into the element store at one per cycle while s_tready is
// high; s_tready drops after the last item until the element is evaluated.
// Evaluation runs from the edge that takes the last item to m_tvalid and
// steps over the nodes of the order (4, 6 or 20). Its length is set by
// the single shared 32x32 multiplier (one product a cycle, pipeline drain
// between dependent steps) and by the divide by six for each field
// component. s_tready rises again at the edge that registers the result.
// Output stream (m_*): one item per element, current then centroid. The
// result sits in an output register; a stalled receiver holds it there while
// the next element loads, and evaluation waits only if the register is still
// full when the next result is ready.
// Config port: cfg_data writes element_order, taken in any cycle.
// Reset: order 1, prior current zero, no result pending; the coordinate,
// potential and tensor stores are not cleared.
module tet_element_current_density (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // val_a, val_b, val_c, val_d
    input  logic [6:0]   s_tuser,   // mode, slot
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // current_x/y/z, centroid_x/y/z
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data
);
    import tecd_pkg::*;

    logic     [1:0] order_reg;
    logic           in_fire, idle;
    dp_cmd_t        cmd;
    dp_stat_t       stat;
    q_t             cur_x, cur_y, cur_z, cen_x, cen_y, cen_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORD_LIN;
        else if (cfg_valid && cfg_ready)
            order_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign in_fire   = s_tvalid && s_tready;

    tecd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire && s_tlast),
        .order (order_reg),
        .stat  (stat),
        .cmd   (cmd),
        .idle  (idle)
    );

    tecd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .load       (in_fire),
        .mode       (s_tuser[1:0]),
        .slot       (s_tuser[6:2]),
        .val_a      (s_tdata[31:0]),
        .val_b      (s_tdata[63:32]),
        .val_c      (s_tdata[95:64]),
        .val_d      (s_tdata[127:96]),
        .order      (order_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .current_x  (cur_x),
        .current_y  (cur_y),
        .current_z  (cur_z),
        .centroid_x (cen_x),
        .centroid_y (cen_y),
        .centroid_z (cen_z)
    );

    assign m_tdata = {cen_z, cen_y, cen_x, cur_z, cur_y, cur_x};

endmodule

/* hdl/tecd_ctrl.sv */
// Sequencer of the element evaluation: issues datapath commands step by step.
module tecd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         order,
    input  tecd_pkg::dp_stat_t stat,
    output tecd_pkg::dp_cmd_t  cmd,
    output logic               idle
);
    import tecd_pkg::*;

    state_t              state_reg, state_next, ret_reg, ret_next;
    logic [1:0]          k_reg, k_next, j_reg, j_next, drain_reg, drain_next;
    logic [NODE_W-1:0]   n_reg, n_next, nfirst, nlast;
    logic                t_reg, t_next;

    assign nfirst = node_first(order);
    assign nlast  = node_last(order);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            t_reg     <= 1'b0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            t_reg     <= t_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        t_next     = t_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_DIFF;
            ST_DIFF:
            begin
                state_next = ST_COF;
                k_next     = 2'd1;
                j_next     = 2'd0;
                t_next     = 1'b0;
            end
            ST_COF:
            begin
                t_next = ~t_reg;
                if (t_reg)
                begin
                    if (j_reg == 2'd2)
                    begin
                        j_next = 2'd0;
                        if (k_reg == 2'd3)
                        begin
                            state_next = ST_DRAIN;
                            ret_next   = ST_C0;
                        end
                        else
                            k_next = k_reg + 2'd1;
                    end
                    else
                        j_next = j_reg + 2'd1;
                end
            end
            ST_C0:
            begin
                state_next = ST_WGT;
                j_next     = 2'd0;
                k_next     = 2'd0;
                n_next     = nfirst;
            end
            ST_WGT:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_DRAIN;
                    ret_next   = ST_POT;
                end
            end
            ST_POT:
            begin
                if (n_reg == nlast)
                begin
                    state_next = ST_DRAIN;
                    ret_next   = ST_DIV;
                end
                else
                begin
                    n_next     = n_reg + NODE_W'(1);
                    state_next = ST_WGT;
                end
            end
            ST_DIV:
                state_next = ST_DIVW;
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    k_next = 2'd0;
                    if (j_reg == 2'd2)
                    begin
                        j_next     = 2'd0;
                        state_next = ST_TEN;
                    end
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        n_next     = nfirst;
                        state_next = ST_WGT;
                    end
                end
            end
            ST_TEN:
            begin
                if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    if (j_reg == 2'd2)
                    begin
                        state_next = ST_DRAIN;
                        ret_next   = ST_OUT;
                    end
                    else
                        j_next = j_reg + 2'd1;
                end
                else
                    k_next = k_reg + 2'd1;
            end
            ST_DRAIN:
            begin
                if (drain_reg == 2'(DRAIN_CYCLES - 1))
                begin
                    drain_next = '0;
                    state_next = ret_reg;
                end
                else
                    drain_next = drain_reg + 2'd1;
            end
            ST_OUT:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.t      = t_reg;
        cmd.j      = j_reg;
        cmd.k      = k_reg;
        cmd.n      = n_reg;
        unique case (state_reg)
            ST_DIFF: cmd.op = OP_DIFF;
            ST_COF:
            begin
                cmd.op     = OP_COF;
                cmd.first  = ~t_reg;
                cmd.commit = t_reg;
            end
            ST_C0: cmd.op = OP_C0;
            ST_WGT:
            begin
                cmd.op     = OP_WGT;
                cmd.first  = (k_reg == 2'd0);
                cmd.commit = (k_reg == 2'd3);
            end
            ST_POT:
            begin
                cmd.op    = OP_POT;
                cmd.first = (n_reg == nfirst);
            end
            ST_DIV:  cmd.op = OP_DIV;
            ST_DIVW: cmd.op = OP_DIVW;
            ST_TEN:
            begin
                cmd.op     = OP_TEN;
                cmd.first  = (k_reg == 2'd0);
                cmd.commit = (k_reg == 2'd2);
            end
            ST_OUT: cmd.op = stat.out_free ? OP_EMIT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

/* hdl/tecd_div6.sv */
// Divider by six for the field scaling, eleven quotient bits a cycle.
module tecd_div6 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tecd_pkg::DIV_W-1:0] mag,
    input  logic                       neg_in,
    output logic                       done,
    output logic [tecd_pkg::DIV_W-1:0] quo,
    output logic                       neg
);
    import tecd_pkg::*;

    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [2:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next, quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic [3:0]        trial;
    logic [2:0]        rem_w;
    logic [DIV_W-1:0]  dvd_w, quo_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    // one round: DIV_STEP restoring steps, remainder stays below six
    always_comb
    begin
        rem_w = rem_reg;
        dvd_w = dvd_reg;
        quo_w = quo_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_w, dvd_w[DIV_W-1]};
            dvd_w = {dvd_w[DIV_W-2:0], 1'b0};
            if (trial >= DIVISOR)
            begin
                rem_w = 3'(trial - DIVISOR);
                quo_w = {quo_w[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_w = trial[2:0];
                quo_w = {quo_w[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_ROUNDS - 1);
            rem_next  = '0;
            dvd_next  = mag;
            neg_next  = neg_in;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_w;
            rem_next = rem_w;
            quo_next = quo_w;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - DIV_CW'(1);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign neg  = neg_reg;

endmodule

/* hdl/tecd_dp.sv */
// Datapath: element storage, shared multiply-accumulate pipe, divider, result register.
module tecd_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  tecd_pkg::dp_cmd_t  cmd,
    output tecd_pkg::dp_stat_t stat,
    input  logic               load,
    input  logic [1:0]         mode,
    input  logic [4:0]         slot,
    input  tecd_pkg::q_t       val_a,
    input  tecd_pkg::q_t       val_b,
    input  tecd_pkg::q_t       val_c,
    input  tecd_pkg::q_t       val_d,
    input  logic [1:0]         order,
    output logic               out_valid,
    input  logic               out_ready,
    output tecd_pkg::q_t       current_x,
    output tecd_pkg::q_t       current_y,
    output tecd_pkg::q_t       current_z,
    output tecd_pkg::q_t       centroid_x,
    output tecd_pkg::q_t       centroid_y,
    output tecd_pkg::q_t       centroid_z
);
    import tecd_pkg::*;

    q_t coord_reg [12];
    q_t pot_reg   [MAX_NODES];
    q_t cond_reg  [9];
    q_t prior_reg [3];
    q_t diff_reg  [9];
    q_t cof_reg   [12];
    q_t cen_reg   [3];
    q_t e_reg     [3];
    q_t cur_reg   [3];
    q_t out_reg   [6];
    q_t w_reg;

    logic signed [PROD_W-1:0] prod_reg;
    acc_t                     term_reg, acc_reg;
    logic signed [FSUM_W-1:0] fsum_reg;
    pipe_ctl_t                c0_ctl, c1_reg, c2_reg, c3_reg;
    logic                     out_valid_reg;

    q_t                       mul_a, mul_b;
    acc_t                     term_ext, term_rnd;
    logic [1:0]               pu, pv, pa, pb;
    logic                     swap;
    logic [1:0]               ax_a, ax_b;
    logic signed [DIV_W-1:0]  fs_ext, fs_abs;
    logic [DIV_W-1:0]         div_mag, div_quo;
    logic                     div_neg_in, div_done, div_neg;
    q_t                       e_sat;

    // cofactor operands: corners p<q other than k, axes u,v after j
    always_comb
    begin
        pa   = (cmd.k == 2'd1) ? 2'd1 : 2'd0;
        pb   = (cmd.k == 2'd3) ? 2'd1 : 2'd2;
        pu   = (cmd.j == 2'd2) ? 2'd0 : cmd.j + 2'd1;
        pv   = (cmd.j == 2'd0) ? 2'd2 : cmd.j - 2'd1;
        swap = (cmd.k == 2'd2) ^ cmd.t;
        ax_a = swap ? pv : pu;
        ax_b = swap ? pu : pv;
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        c0_ctl = '0;
        c0_ctl.tgt = TGT_NONE;
        c0_ctl.j   = cmd.j;
        c0_ctl.first = cmd.first;
        case (cmd.op)
            OP_COF:
            begin
                mul_a      = diff_reg[idx3(pa, ax_a)];
                mul_b      = diff_reg[idx3(pb, ax_b)];
                c0_ctl.vld = 1'b1;
                c0_ctl.neg = cmd.t;
                c0_ctl.tgt = cmd.commit ? TGT_COF : TGT_NONE;
                c0_ctl.idx = idx3(cmd.k, cmd.j);
            end
            OP_WGT:
            begin
                mul_a      = cof_reg[idx3(cmd.k, cmd.j)];
                mul_b      = DATA_W'(shape_coef(order, 5'(cmd.n), cmd.k));
                c0_ctl.vld = 1'b1;
                c0_ctl.tgt = cmd.commit ? TGT_WGT : TGT_NONE;
            end
            OP_POT:
            begin
                mul_a        = w_reg;
                mul_b        = pot_reg[cmd.n];
                c0_ctl.vld   = 1'b1;
                c0_ctl.rnd   = 1'b1;
                c0_ctl.acc_b = 1'b1;
            end
            OP_TEN:
            begin
                mul_a        = cond_reg[idx3(cmd.k, cmd.j)];
                mul_b        = e_reg[cmd.k];
                c0_ctl.vld   = 1'b1;
                c0_ctl.rnd   = 1'b1;
                c0_ctl.prior = cmd.first;
                c0_ctl.tgt   = cmd.commit ? TGT_CUR : TGT_NONE;
            end
            default: ;
        endcase
    end

    assign term_ext = ACC_W'(prod_reg);
    assign term_rnd = c1_reg.rnd ? rnd_shr(term_ext, 16) : term_ext;

    // field sum into the divider: e = -fsum / 6, rounded half away
    assign fs_ext     = DIV_W'(fsum_reg);
    assign fs_abs     = fs_ext[DIV_W-1] ? -fs_ext : fs_ext;
    assign div_mag    = DIV_W'(fs_abs) + DIV_W'(DIV_ROUND);
    assign div_neg_in = !fsum_reg[FSUM_W-1] && (fsum_reg != '0);

    tecd_div6 u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.op == OP_DIV),
        .mag    (div_mag),
        .neg_in (div_neg_in),
        .done   (div_done),
        .quo    (div_quo),
        .neg    (div_neg)
    );

    always_comb
    begin
        if (div_neg)
            e_sat = (div_quo > (DIV_W'(1) << (DATA_W - 1))) ? Q_MIN : -q_t'(div_quo[DATA_W-1:0]);
        else
            e_sat = (div_quo[DIV_W-1:DATA_W-1] != '0) ? Q_MAX : q_t'(div_quo[DATA_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                prior_reg[i] <= '0;
        end
        else
        begin
            c1_reg <= c0_ctl;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.op == OP_EMIT)
            begin
                for (int i = 0; i < 3; i++)
                    prior_reg[i] <= '0;
            end
            else if (load && mode == MODE_PRIOR)
            begin
                prior_reg[0] <= val_a;
                prior_reg[1] <= val_b;
                prior_reg[2] <= val_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            case (mode) inside
                MODE_CORNER, MODE_NODE:
                begin
                    if (mode == MODE_CORNER && slot < 5'd4)
                    begin
                        coord_reg[idx3(slot[1:0], 2'd0)] <= val_a;
                        coord_reg[idx3(slot[1:0], 2'd1)] <= val_b;
                        coord_reg[idx3(slot[1:0], 2'd2)] <= val_c;
                    end
                    if (slot < 5'(MAX_NODES))
                        pot_reg[slot] <= val_d;
                end
                MODE_COND:
                begin
                    if (slot < 5'd3)
                    begin
                        cond_reg[idx3(slot[1:0], 2'd0)] <= val_a;
                        cond_reg[idx3(slot[1:0], 2'd1)] <= val_b;
                        cond_reg[idx3(slot[1:0], 2'd2)] <= val_c;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.op == OP_DIFF)
        begin
            for (int k = 1; k < 4; k++)
                for (int a = 0; a < 3; a++)
                    diff_reg[4'(3 * (k - 1) + a)] <=
                        sat32(ext(coord_reg[4'(3 * k + a)]) - ext(coord_reg[4'(a)]));
            for (int a = 0; a < 3; a++)
                cen_reg[a] <= sat32(rnd_shr(ext(coord_reg[4'(a)]) + ext(coord_reg[4'(3 + a)])
                    + ext(coord_reg[4'(6 + a)]) + ext(coord_reg[4'(9 + a)]), 2));
        end

        // corner 0 cofactor closes the sum of the other three
        if (cmd.op == OP_C0)
            for (int a = 0; a < 3; a++)
                cof_reg[4'(a)] <= sat32(-(ext(cof_reg[4'(3 + a)]) + ext(cof_reg[4'(6 + a)])
                    + ext(cof_reg[4'(9 + a)])));

        prod_reg <= mul_a * mul_b;
        term_reg <= c1_reg.neg ? -term_rnd : term_rnd;

        if (c2_reg.vld)
        begin
            if (c2_reg.acc_b)
                fsum_reg <= (c2_reg.first ? '0 : fsum_reg) + FSUM_W'(term_reg);
            else if (c2_reg.prior)
                acc_reg <= ext(prior_reg[c2_reg.j]) + term_reg;
            else
                acc_reg <= (c2_reg.first ? '0 : acc_reg) + term_reg;
        end

        if (c3_reg.vld)
        begin
            case (c3_reg.tgt)
                TGT_COF: cof_reg[c3_reg.idx] <= sat32(rnd_shr(acc_reg, 16));
                TGT_WGT: w_reg <= sat32(rnd_shr(acc_reg, 5));
                TGT_CUR: cur_reg[c3_reg.j] <= sat32(acc_reg);
                default: ;
            endcase
        end

        if (cmd.op == OP_DIVW && div_done)
            e_reg[cmd.j] <= e_sat;

        if (cmd.op == OP_EMIT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i]     <= cur_reg[i];
                out_reg[i + 3] <= cen_reg[i];
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign current_x  = out_reg[0];
    assign current_y  = out_reg[1];
    assign current_z  = out_reg[2];
    assign centroid_x = out_reg[3];
    assign centroid_y = out_reg[4];
    assign centroid_z = out_reg[5];

endmodule

/* hdl/tecd_checker.sv */
// Port-level checker of the element current density block and its bind.
`include "tet_element_current_density_assert.svh"

module tecd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    `TECD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `TECD_ASSERT_NXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input taken during evaluation")
    `TECD_ASSERT_NXT(a_ready_mid_elem, s_tvalid && s_tready && !s_tlast, s_tready, "input stalled inside an element")
    `TECD_ASSERT_IMP(a_result_from_eval, $rose(m_tvalid), $past(!s_tready), "result without evaluation")

endmodule

bind tet_element_current_density tecd_checker u_tecd_checker (.*);

/* tb/tet_element_current_density_check.sv */
// Checker for the element current density block: predicts each element's result and compares.
module tet_element_current_density_check (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // val_a, val_b, val_c, val_d
    input  logic [6:0]   s_tuser,   // mode, slot
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,   // current_x/y/z, centroid_x/y/z
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_data,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tecd_pkg::*;

    typedef logic signed [95:0] wide_t;

    localparam wide_t ONE_Q = 96'sd65536;

    // gradient weights per order, node, corner; units of 1/32
    localparam int WGT [3][20][4] = '{
        '{'{32,0,0,0},'{0,32,0,0},'{0,0,32,0},'{0,0,0,32},
          '{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},
          '{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},
          '{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0}},
        '{'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},
          '{32,32,0,0},'{32,0,32,0},'{32,0,0,32},'{0,32,32,0},'{0,32,0,32},
          '{0,0,32,32},
          '{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},
          '{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0}},
        '{'{-13,0,0,0},'{0,-13,0,0},'{0,0,-13,0},'{0,0,0,-13},
          '{18,-9,0,0},'{-9,18,0,0},'{18,0,-9,0},'{-9,0,18,0},'{18,0,0,-9},
          '{-9,0,0,18},
          '{0,18,-9,0},'{0,-9,18,0},'{0,18,0,-9},'{0,-9,0,18},'{0,0,18,-9},
          '{0,0,-9,18},
          '{54,54,54,0},'{54,54,0,54},'{54,0,54,54},'{0,54,54,54}}
    };

    logic [1:0] order_reg;
    wide_t      corner [4][3];
    wide_t      pot [20];
    wide_t      tensor [3][3];   // [column][row]
    wide_t      prior [3];
    logic [191:0] expected_q [$];

    function automatic wide_t clamp32(input wide_t x);
        if (x > 96'sd2147483647)
            return 96'sd2147483647;
        if (x < -96'sd2147483648)
            return -96'sd2147483648;
        return x;
    endfunction

    // divide, round to nearest, ties away from zero
    function automatic wide_t div_round(input wide_t x, input wide_t d);
        wide_t m;
        wide_t q;
        m = (x < 0) ? -x : x;
        q = (m + d / 2) / d;
        return (x < 0) ? -q : q;
    endfunction

    function automatic wide_t cofactor(input wide_t a, input wide_t b,
                                       input wide_t c, input wide_t d);
        return clamp32(div_round(a * b - c * d, ONE_Q));
    endfunction

    function automatic logic [191:0] element_current();
        wide_t dx [4];
        wide_t dy [4];
        wide_t dz [4];
        wide_t cf [4][3];
        wide_t field [3];
        wide_t acc;
        wide_t w;
        wide_t cen;
        int    ord;
        logic [191:0] r;
        for (int k = 1; k < 4; k++)
        begin
            dx[k] = clamp32(corner[k][0] - corner[0][0]);
            dy[k] = clamp32(corner[k][1] - corner[0][1]);
            dz[k] = clamp32(corner[k][2] - corner[0][2]);
        end
        cf[1][0] = cofactor(dy[2], dz[3], dz[2], dy[3]);
        cf[1][1] = cofactor(dz[2], dx[3], dx[2], dz[3]);
        cf[1][2] = cofactor(dx[2], dy[3], dy[2], dx[3]);
        cf[2][0] = cofactor(dz[1], dy[3], dy[1], dz[3]);
        cf[2][1] = cofactor(dx[1], dz[3], dz[1], dx[3]);
        cf[2][2] = cofactor(dy[1], dx[3], dx[1], dy[3]);
        cf[3][0] = cofactor(dy[1], dz[2], dz[1], dy[2]);
        cf[3][1] = cofactor(dz[1], dx[2], dx[1], dz[2]);
        cf[3][2] = cofactor(dx[1], dy[2], dy[1], dx[2]);
        for (int j = 0; j < 3; j++)
            cf[0][j] = clamp32(-(cf[1][j] + cf[2][j] + cf[3][j]));
        // order zero behaves as linear
        ord = (order_reg == 2'd0) ? 0 : int'(order_reg) - 1;
        for (int j = 0; j < 3; j++)
        begin
            acc = 0;
            for (int n = 0; n < 20; n++)
            begin
                w = 0;
                for (int k = 0; k < 4; k++)
                    w += wide_t'(WGT[ord][n][k]) * cf[k][j];
                w = clamp32(div_round(w, 32));
                if (w != 0)
                    acc += div_round(w * pot[n], ONE_Q);
            end
            field[j] = clamp32(div_round(-acc, 6));
        end
        for (int j = 0; j < 3; j++)
        begin
            acc = prior[j];
            for (int k = 0; k < 3; k++)
                acc += div_round(tensor[k][j] * field[k], ONE_Q);
            r[32*j +: 32] = 32'(clamp32(acc));
            cen = div_round(corner[0][j] + corner[1][j] + corner[2][j] + corner[3][j], 4);
            r[96 + 32*j +: 32] = 32'(clamp32(cen));
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg = ORD_LIN;
            for (int j = 0; j < 3; j++)
                prior[j] = 0;
            expected_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            logic [1:0]   mode;
            logic [4:0]   slot;
            wide_t        va, vb, vc, vd;
            logic [191:0] want;
            if (cfg_valid && cfg_ready)
                order_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                mode = s_tuser[1:0];
                slot = s_tuser[6:2];
                va = wide_t'($signed(s_tdata[31:0]));
                vb = wide_t'($signed(s_tdata[63:32]));
                vc = wide_t'($signed(s_tdata[95:64]));
                vd = wide_t'($signed(s_tdata[127:96]));
                if (mode == MODE_CORNER || mode == MODE_NODE)
                begin
                    // corner slots beyond three keep only the potential
                    if (mode == MODE_CORNER && slot < 4)
                    begin
                        corner[slot[1:0]][0] = va;
                        corner[slot[1:0]][1] = vb;
                        corner[slot[1:0]][2] = vc;
                    end
                    if (slot < MAX_NODES)
                        pot[slot] = vd;
                end
                else if (mode == MODE_COND)
                begin
                    if (slot < 3)
                    begin
                        tensor[slot[1:0]][0] = va;
                        tensor[slot[1:0]][1] = vb;
                        tensor[slot[1:0]][2] = vc;
                    end
                end
                else
                begin
                    prior[0] = va;
                    prior[1] = vb;
                    prior[2] = vc;
                end
                if (s_tlast)
                begin
                    expected_q.push_back(element_current());
                    for (int j = 0; j < 3; j++)
                        prior[j] = 0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result item %h", m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    for (int f = 0; f < 6; f++)
                    begin
                        if (m_tdata[32*f +: 32] !== want[32*f +: 32])
                        begin
                            errors++;
                            if (errors <= 10)
                                $display("field %0d mismatch: expected %h got %h",
                                         f, want[32*f +: 32], m_tdata[32*f +: 32]);
                        end
                    end
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

/* tb/tet_element_current_density_test.sv */
// Top of the element current density testbench: clock, reset, stimulus and verdict.
module tet_element_current_density_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tecd_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // val_a, val_b, val_c, val_d
    logic [6:0]   s_tuser;   // mode, slot
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;   // current_x/y/z, centroid_x/y/z
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_data;
    int           errors;
    int           pending;

    // sender runs without gaps while set
    bit tx_calm;
    // receiver runs without stalls while set
    bit rx_calm;
    // asks the receiver for one long stall
    bit hold_req;

    tet_element_current_density i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tet_element_current_density_check i_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, one long hold-off on request so the output
    // register stays full and the block backs up into its input.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = rx_calm || ($urandom_range(0, 99) >= 13);
        end
    end

    // Q16.16 value: mostly modest magnitudes, some extremes and full range
    function automatic logic [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'h7fffffff;
        if (sel == 1)
            return 32'h80000000;
        if (sel <= 3)
            return $urandom;
        return 32'($signed($urandom) >>> $urandom_range(8, 14));
    endfunction

    // one item, held until accepted; valid stays high for a following item
    task automatic send_item(input logic [1:0] mode, input logic [4:0] slot,
                             input logic [31:0] va, input logic [31:0] vb,
                             input logic [31:0] vc, input logic [31:0] vd,
                             input logic last);
        if (!tx_calm && $urandom_range(0, 99) < 13)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tuser  = {slot, mode};
        s_tdata  = {vd, vc, vb, va};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // quiet the input and wait for every result to come back
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_order(input logic [1:0] ord);
        cfg_data  = ord;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_items(input int count);
        logic [1:0] mode;
        logic [4:0] slot;
        for (int i = 0; i < count; i++)
        begin
            mode = 2'($urandom_range(0, 3));
            // mostly in-range slots; some anywhere to hit ignored writes
            if ($urandom_range(0, 9) == 0)
                slot = 5'($urandom_range(0, 31));
            else if (mode == MODE_COND)
                slot = 5'($urandom_range(0, 2));
            else if (mode == MODE_CORNER)
                slot = 5'($urandom_range(0, 4) == 0 ? $urandom_range(4, 19)
                                                   : $urandom_range(0, 3));
            else
                slot = 5'($urandom_range(0, 19));
            send_item(mode, slot, pick_value(), pick_value(), pick_value(),
                      pick_value(),
                      (i == count - 1) || ($urandom_range(0, 5) == 0));
        end
    endtask

    initial
    begin
        logic [1:0] phase_order [5];
        phase_order = '{ORD_CUB, ORD_QUAD, 2'd0, ORD_LIN, ORD_CUB};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        tx_calm   = 0;
        rx_calm   = 0;
        hold_req  = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: load every store once, so no later read hits an
        // unwritten entry, then evaluate with the reset order (linear).
        send_item(MODE_CORNER, 5'd0, 32'h00000000, 32'h00000000, 32'h00000000,
                  32'h00010000, 1'b0);
        send_item(MODE_CORNER, 5'd1, 32'h00010000, 32'h00000000, 32'h00000000,
                  32'h00020000, 1'b0);
        send_item(MODE_CORNER, 5'd2, 32'h00000000, 32'h00010000, 32'h00000000,
                  32'hfffe0000, 1'b0);
        send_item(MODE_CORNER, 5'd3, 32'h00000000, 32'h00000000, 32'h00010000,
                  32'h00008000, 1'b0);
        for (int n = 4; n < MAX_NODES; n++)
            send_item(MODE_NODE, 5'(n), $urandom, $urandom, $urandom,
                      32'($signed($urandom) >>> 12), 1'b0);
        send_item(MODE_COND, 5'd0, 32'h00010000, 32'h00000000, 32'h00000000, 0, 1'b0);
        send_item(MODE_COND, 5'd1, 32'h00000000, 32'h00020000, 32'h00000000, 0, 1'b0);
        send_item(MODE_COND, 5'd2, 32'h00000000, 32'h00000000, 32'hffff0000, 0, 1'b1);
        // prior current, corner slot above three, ignored slots, extremes
        send_item(MODE_PRIOR, 5'd31, 32'h7fffffff, 32'h80000000, 32'h00000001,
                  0, 1'b0);
        send_item(MODE_CORNER, 5'd7, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 1'b0);
        send_item(MODE_NODE, 5'd25, 0, 0, 0, 32'h7fffffff, 1'b0);
        send_item(MODE_COND, 5'd5, 32'h80000000, 32'h80000000, 32'h80000000, 0, 1'b0);
        send_item(MODE_CORNER, 5'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 1'b0);
        send_item(MODE_CORNER, 5'd2, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 1'b1);
        drain_results();

        // Random phases, one order each; the order is only changed at rest.
        for (int p = 0; p < 5; p++)
        begin
            write_order(phase_order[p]);
            tx_calm = (p == 3);
            rx_calm = (p == 3);
            if (p == 1)
                hold_req = 1;
            if (p == 2)
            begin
                random_items(48);
                // sender pauses until all results are back
                drain_results();
                random_items(48);
            end
            else
                random_items(96);
            drain_results();
        end

        s_tvalid = 1'b0;
        // one evaluation of the slowest order plus margin
        repeat (1000) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("tet_element_current_density_test passed");
        else
            $display("tet_element_current_density_test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tet_element_current_density_test failed");
        $finish;
    end
endmodule
